[hdl/pal2g_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pal2g_pkg
// Shared types and constants for the palette pixel to gray converter.
// -----------------------------------------------------------------------------
package pal2g_pkg;

   localparam int unsigned PAL_ENTRIES = 256;
   localparam int unsigned IDX_W       = 8;
   localparam int unsigned COMP_W      = 8;
   localparam int unsigned SIZE_W      = 9;
   localparam int unsigned PROD_W      = 24;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 9;

   localparam logic [15:0] COEF_RED   = 16'd19595;
   localparam logic [15:0] COEF_GREEN = 16'd38470;
   localparam logic [15:0] COEF_BLUE  = 16'd7471;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_PIXEL = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_MODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_SIZE  = 2'd2;

   localparam logic       FMT_BMP = 1'b0;

   localparam logic [1:0] MODE_PALETTE = 2'd0;
   localparam logic [1:0] MODE_RGB     = 2'd1;

   localparam logic [2:0] SEL_OOR   = 3'd0;
   localparam logic [2:0] SEL_IDX16 = 3'd1;
   localparam logic [2:0] SEL_TABLE = 3'd2;
   localparam logic [2:0] SEL_LUMA  = 3'd3;
   localparam logic [2:0] SEL_RED   = 3'd4;

   typedef struct packed {
      logic [1:0]        operation;
      logic [IDX_W-1:0]  index;
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } req_word_type;

   typedef struct packed {
      logic [COMP_W-1:0] gray;
      logic              index_out_of_range;
   } rsp_word_type;

endpackage

[hdl/pal2g_luma.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pal2g_luma
// Two-stage luma unit: registered constant products, then registered sum >> 16.
// -----------------------------------------------------------------------------
module pal2g_luma (
   input  wire logic                       clock,
   input  wire logic                       advance,
   input  wire logic [pal2g_pkg::COMP_W-1:0] red,
   input  wire logic [pal2g_pkg::COMP_W-1:0] green,
   input  wire logic [pal2g_pkg::COMP_W-1:0] blue,
   output logic      [pal2g_pkg::COMP_W-1:0] luma
);
   import pal2g_pkg::*;

   logic [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic [PROD_W-1:0] prod_r_in, prod_g_in, prod_b_in;
   logic [PROD_W-1:0] sum_in;
   logic [COMP_W-1:0] luma_ff;

   assign prod_r_in = PROD_W'(red) * PROD_W'(COEF_RED);
   assign prod_g_in = PROD_W'(green) * PROD_W'(COEF_GREEN);
   assign prod_b_in = PROD_W'(blue) * PROD_W'(COEF_BLUE);
   assign sum_in    = prod_r_ff + prod_g_ff + prod_b_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_r_ff <= prod_r_in;
         prod_g_ff <= prod_g_in;
         prod_b_ff <= prod_b_in;
         luma_ff   <= sum_in[PROD_W-1:16];
      end
   end

   assign luma = luma_ff;

endmodule
`default_nettype wire

[hdl/palette_pixel_to_gray_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// palette_pixel_to_gray_core
// Palette loading and pixel to 8-bit gray conversion, four register stages.
//
//   channel | ports                      | moves
//   --------+----------------------------+----------------------------------
//   req     | req_valid/ready, req_word  | operation, index, red/green/blue
//   rsp     | rsp_valid/ready, rsp_word  | gray, index_out_of_range
//   csr     | csr_we, csr_index/wdata    | source_format, pixel_mode, size
//
// One word per cycle while no result is held; a pixel's result word passes
// through the product, sum, table read and output registers.
// Start and load words give no result. All stages advance together; a held
// result stalls every stage and req_ready. Synchronous reset clears valid bits,
// csr registers, sets the gray-palette flag; the table is undefined until loaded.
// -----------------------------------------------------------------------------
module palette_pixel_to_gray_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire pal2g_pkg::req_word_type       req_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output pal2g_pkg::rsp_word_type            rsp_word,
   input  wire logic                          csr_we,
   input  wire logic [pal2g_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pal2g_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pal2g_pkg::*;

   logic              fmt_ff;
   logic [1:0]        mode_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              mono_pal_ff, mono_pal_in;

   logic              adv, accept;
   logic [SIZE_W-1:0] size_clamp;
   logic [2:0]        sel_in;

   logic              s1_valid_ff;
   logic [1:0]        s1_op_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [COMP_W-1:0] s1_red_ff;
   logic [2:0]        s1_sel_ff;

   logic              s2_valid_ff;
   logic [1:0]        s2_op_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [COMP_W-1:0] s2_red_ff;
   logic [2:0]        s2_sel_ff;
   logic [COMP_W-1:0] s2_luma;

   logic              s3_valid_ff;
   logic [IDX_W-1:0]  s3_idx_ff;
   logic [COMP_W-1:0] s3_red_ff;
   logic [COMP_W-1:0] s3_luma_ff;
   logic [2:0]        s3_sel_ff;
   logic [COMP_W-1:0] rd_ff;

   logic [COMP_W-1:0] luma_mem [PAL_ENTRIES];

   logic              out_valid_ff;
   rsp_word_type      out_word_ff, out_word_in;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= 1'b0;
         mode_ff <= 2'd0;
         size_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SOURCE_FORMAT: fmt_ff  <= csr_wdata[0];
            REG_PIXEL_MODE:    mode_ff <= csr_wdata[1:0];
            REG_PALETTE_SIZE:  size_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   assign size_clamp = (size_ff > SIZE_W'(PAL_ENTRIES)) ? SIZE_W'(PAL_ENTRIES) : size_ff;

   always_comb begin
      mono_pal_in = mono_pal_ff;
      if (accept) begin
         if (req_word.operation == OP_START) begin
            mono_pal_in = 1'b1;
         end else if (req_word.operation == OP_LOAD &&
                      {1'b0, req_word.index} < size_ff &&
                      (req_word.red != req_word.green || req_word.red != req_word.blue)) begin
            mono_pal_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (mode_ff == MODE_PALETTE) begin
         if ({1'b0, req_word.index} >= size_clamp) begin
            sel_in = SEL_OOR;
         end else if ((size_ff == SIZE_W'(16) && !mono_pal_ff) ||
                      (fmt_ff == FMT_BMP && size_ff == SIZE_W'(2))) begin
            sel_in = SEL_IDX16;
         end else begin
            sel_in = SEL_TABLE;
         end
      end else if (mode_ff == MODE_RGB) begin
         sel_in = SEL_LUMA;
      end else begin
         sel_in = SEL_RED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_pal_ff  <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mono_pal_ff <= mono_pal_in;
         if (adv) begin
            s1_valid_ff  <= accept && req_word.operation != OP_SPARE;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff && s2_op_ff == OP_PIXEL;
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff   <= req_word.operation;
         s1_idx_ff  <= req_word.index;
         s1_red_ff  <= req_word.red;
         s1_sel_ff  <= sel_in;
         s2_op_ff   <= s1_op_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_red_ff  <= s1_red_ff;
         s2_sel_ff  <= s1_sel_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_red_ff  <= s2_red_ff;
         s3_sel_ff  <= s2_sel_ff;
         s3_luma_ff <= s2_luma;
         out_word_ff <= out_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s2_valid_ff && s2_op_ff == OP_LOAD) begin
            luma_mem[s2_idx_ff] <= s2_luma;
         end
         rd_ff <= luma_mem[s2_idx_ff];
      end
   end

   pal2g_luma u_luma (
      .clock   (clock),
      .advance (adv),
      .red     (req_word.red),
      .green   (req_word.green),
      .blue    (req_word.blue),
      .luma    (s2_luma)
   );

   always_comb begin
      out_word_in.index_out_of_range = 1'b0;
      case (s3_sel_ff)
         SEL_OOR: begin
            out_word_in.gray               = '0;
            out_word_in.index_out_of_range = 1'b1;
         end
         SEL_IDX16: out_word_in.gray = {s3_idx_ff[3:0], 4'd0};
         SEL_TABLE: out_word_in.gray = rd_ff;
         SEL_LUMA:  out_word_in.gray = s3_luma_ff;
         default:   out_word_in.gray = s3_red_ff;
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
`default_nettype wire

[tb/pal2g_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pal2g_checker
// Watches the req, rsp and csr ports of the palette to gray converter. Keeps
// its own palette shade table, gray-palette flag and register copies, predicts
// the gray word of every accepted pixel and compares each result word with the
// oldest prediction. Hands the failure count and the number of outstanding
// predictions to the testbench top.
// -----------------------------------------------------------------------------
module pal2g_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire pal2g_pkg::req_word_type       req_word,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire pal2g_pkg::rsp_word_type       rsp_word,
   input  wire logic                          csr_we,
   input  wire logic [pal2g_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pal2g_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);
   import pal2g_pkg::*;

   logic [COMP_W-1:0] shade_table [PAL_ENTRIES];
   logic              mono_pal = 1'b1;
   logic              fmt_reg = FMT_BMP;
   logic [1:0]        mode_reg = MODE_PALETTE;
   logic [SIZE_W-1:0] size_reg = '0;
   rsp_word_type      gray_expected [$];
   rsp_word_type      want;
   int                failures = 0;

   function automatic logic [COMP_W-1:0] luma_of(input logic [COMP_W-1:0] r,
                                                 input logic [COMP_W-1:0] g,
                                                 input logic [COMP_W-1:0] b);
      logic [31:0] acc;
      acc = 32'(r) * 32'(COEF_RED) + 32'(g) * 32'(COEF_GREEN)
          + 32'(b) * 32'(COEF_BLUE);
      return acc[23:16];
   endfunction

   function automatic void absorb_word(input req_word_type w);
      rsp_word_type      res;
      logic [SIZE_W-1:0] span;
      span = (size_reg > SIZE_W'(PAL_ENTRIES)) ? SIZE_W'(PAL_ENTRIES) : size_reg;
      res  = '0;
      case (w.operation)
         OP_START: mono_pal = 1'b1;
         OP_LOAD: begin
            shade_table[w.index] = luma_of(w.red, w.green, w.blue);
            if (SIZE_W'(w.index) < size_reg &&
                (w.red != w.green || w.red != w.blue))
               mono_pal = 1'b0;
         end
         OP_PIXEL: begin
            if (mode_reg == MODE_PALETTE) begin
               if (SIZE_W'(w.index) >= span)
                  res.index_out_of_range = 1'b1;
               else if ((size_reg == SIZE_W'(16) && !mono_pal) ||
                        (fmt_reg == FMT_BMP && size_reg == SIZE_W'(2)))
                  res.gray = {w.index[3:0], 4'b0000};
               else
                  res.gray = shade_table[w.index];
            end else if (mode_reg == MODE_RGB) begin
               res.gray = luma_of(w.red, w.green, w.blue);
            end else begin
               res.gray = w.red;
            end
            gray_expected.push_back(res);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gray_expected.delete();
         mono_pal = 1'b1;
         fmt_reg  = FMT_BMP;
         mode_reg = MODE_PALETTE;
         size_reg = '0;
         failures = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SOURCE_FORMAT: fmt_reg  = csr_wdata[0];
               REG_PIXEL_MODE:    mode_reg = csr_wdata[1:0];
               REG_PALETTE_SIZE:  size_reg = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (gray_expected.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected word gray=%0d oor=%0b", $realtime,
                           rsp_word.gray, rsp_word.index_out_of_range);
               failures++;
            end else begin
               want = gray_expected.pop_front();
               if (rsp_word.gray !== want.gray ||
                   rsp_word.index_out_of_range !== want.index_out_of_range) begin
                  if (failures < 10)
                     $display("%0t: expected gray=%0d oor=%0b, got gray=%0d oor=%0b",
                              $realtime, want.gray, want.index_out_of_range,
                              rsp_word.gray, rsp_word.index_out_of_range);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready)
            absorb_word(req_word);
      end
      fail_count  <= failures;
      outstanding <= gray_expected.size();
   end

endmodule

[tb/tb_palette_pixel_to_gray_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_palette_pixel_to_gray_core
// Stimulus and verdict for the palette pixel to gray converter. A short
// directed part walks the register settings, palette lookups, out-of-range
// indexes, RGB luma and single-channel pass-through; random phases then build
// palettes of many sizes and stream pixels through them under random idling
// on both channels, with one long receiver hold-off. Checking is done by
// pal2g_checker.
// -----------------------------------------------------------------------------
module tb_palette_pixel_to_gray_core;
   import pal2g_pkg::*;

   localparam int         ITEM_TARGET    = 750;
   localparam int         CALM_TAIL      = 100;
   localparam int         LONG_HOLD      = 60;
   localparam int         DRAIN_CYCLES   = 10;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam logic       FMT_PNG        = 1'b1;
   localparam logic [1:0] MODE_GRAY      = 2'd2;
   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int         SIZE_TOUR [8]  = '{16, 2, 256, 511, 0, 1, 255, 16};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_ready;
   req_word_type          req_word   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  calm       = 1'b0;
   logic                  hold_start = 1'b0;
   int                    fail_count;
   int                    outstanding;
   int                    words_sent  = 0;
   int                    idle_cycles = 0;
   int                    hold_left   = 0;
   int                    stall_left  = 0;
   int                    phase_no    = 0;
   int                    cur_size    = 0;
   bit                    written_entry [PAL_ENTRIES];

   palette_pixel_to_gray_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pal2g_checker score_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (hold_start)
         hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [COMP_W-1:0] rand_comp();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return COMP_W'($urandom);
      endcase
   endfunction

   function automatic req_word_type rand_word(input logic [1:0] op);
      req_word_type w;
      w.operation = op;
      w.index     = IDX_W'($urandom);
      w.red       = rand_comp();
      w.green     = rand_comp();
      w.blue      = rand_comp();
      return w;
   endfunction

   function automatic int pick_index();
      int span;
      int cand;
      int k;
      span = (cur_size > PAL_ENTRIES) ? PAL_ENTRIES : cur_size;
      if (span < PAL_ENTRIES && $urandom_range(0, 4) == 0)
         return $urandom_range(span, PAL_ENTRIES - 1);
      if (span > 0) begin
         for (k = 0; k < 16; k++) begin
            cand = $urandom_range(0, span - 1);
            if (written_entry[cand])
               return cand;
         end
         for (cand = 0; cand < span; cand++)
            if (written_entry[cand])
               return cand;
      end
      if (span < PAL_ENTRIES)
         return $urandom_range(span, PAL_ENTRIES - 1);
      return -1;
   endfunction

   task automatic push_word(input req_word_type w);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (w.operation != OP_SPARE)
         words_sent++;
   endtask

   task automatic send_start();
      push_word(rand_word(OP_START));
   endtask

   task automatic send_load(input int idx, input logic [COMP_W-1:0] r,
                            input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
      req_word_type w;
      w       = rand_word(OP_LOAD);
      w.index = IDX_W'(idx);
      w.red   = r;
      w.green = g;
      w.blue  = b;
      written_entry[idx] = 1'b1;
      push_word(w);
   endtask

   task automatic send_pixel(input int idx, input logic [COMP_W-1:0] r,
                             input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
      req_word_type w;
      w       = rand_word(OP_PIXEL);
      w.index = IDX_W'(idx);
      w.red   = r;
      w.green = g;
      w.blue  = b;
      push_word(w);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // drain first, then write all three registers on back-to-back edges
   task automatic set_config(input logic fmt, input logic [1:0] mode, input int size);
      settle();
      csr_we    <= 1'b1;
      csr_index <= REG_SOURCE_FORMAT;
      csr_wdata <= {8'($urandom), fmt};
      @(posedge clock);
      csr_index <= REG_PIXEL_MODE;
      csr_wdata <= {7'($urandom), mode};
      @(posedge clock);
      csr_index <= REG_PALETTE_SIZE;
      csr_wdata <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_size = size;
   endtask

   task automatic run_phase(input int num);
      logic             fmt;
      logic [1:0]       mode;
      int               size;
      int               loads;
      int               pixels;
      int               k;
      int               idx;
      int               pick;
      bit               gray_pal;
      logic [COMP_W-1:0] r;
      req_word_type     w;
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? MODE_PALETTE : (pick < 8) ? MODE_RGB :
             (pick == 8) ? MODE_GRAY : MODE_SPARE;
      fmt  = 1'($urandom_range(0, 1));
      if (num < 8) begin
         size = SIZE_TOUR[num];
         mode = MODE_PALETTE;
         fmt  = num[1];
      end else if ($urandom_range(0, 3) == 0) begin
         size = SIZE_TOUR[$urandom_range(0, 7)];
      end else begin
         size = $urandom_range(0, 20);
      end
      set_config(fmt, mode, size);
      calm <= (words_sent >= ITEM_TARGET - CALM_TAIL) || ($urandom_range(0, 4) == 0);
      gray_pal = ($urandom_range(0, 2) == 0);
      send_start();
      loads = (size <= 24) ? size : $urandom_range(4, 24);
      for (k = 0; k < loads; k++) begin
         idx = (size <= 24) ? k : $urandom_range(0, ((size > 256) ? 256 : size) - 1);
         r   = rand_comp();
         if (gray_pal || $urandom_range(0, 3) == 0)
            send_load(idx, r, r, r);
         else
            send_load(idx, r, rand_comp(), rand_comp());
      end
      pixels = $urandom_range(6, 30);
      for (k = 0; k < pixels; k++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            w = rand_word(OP_SPARE);
            push_word(w);
         end else if (pick == 1) begin
            send_start();
         end else if (pick == 2) begin
            send_load($urandom_range(0, PAL_ENTRIES - 1), rand_comp(), rand_comp(),
                      rand_comp());
         end else if (mode == MODE_PALETTE) begin
            idx = pick_index();
            if (idx >= 0)
               send_pixel(idx, rand_comp(), rand_comp(), rand_comp());
         end else begin
            send_pixel($urandom_range(0, PAL_ENTRIES - 1), rand_comp(), rand_comp(),
                       rand_comp());
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_config(FMT_BMP, MODE_PALETTE, 4);
      send_start();
      send_load(0, 8'd255, 8'd255, 8'd255);
      send_load(1, 8'd0, 8'd0, 8'd0);
      send_load(2, 8'd255, 8'd0, 8'd0);
      send_load(3, 8'd0, 8'd0, 8'd255);
      send_pixel(0, 8'd0, 8'd0, 8'd0);
      send_pixel(1, 8'd255, 8'd255, 8'd255);
      send_pixel(2, 8'd0, 8'd0, 8'd0);
      send_pixel(3, 8'd0, 8'd0, 8'd0);
      send_pixel(4, 8'd0, 8'd0, 8'd0);
      send_pixel(255, 8'd0, 8'd0, 8'd0);

      set_config(FMT_BMP, MODE_PALETTE, 2);
      send_pixel(1, 8'd0, 8'd0, 8'd0);
      send_pixel(0, 8'd0, 8'd0, 8'd0);
      send_pixel(2, 8'd0, 8'd0, 8'd0);

      set_config(FMT_PNG, MODE_PALETTE, 0);
      send_pixel(0, 8'd0, 8'd0, 8'd0);

      set_config(FMT_PNG, MODE_RGB, 0);
      send_pixel(0, 8'd255, 8'd255, 8'd255);
      send_pixel(0, 8'd0, 8'd0, 8'd0);
      send_pixel(0, 8'd255, 8'd0, 8'd0);
      send_pixel(0, 8'd0, 8'd255, 8'd0);
      send_pixel(0, 8'd0, 8'd0, 8'd255);
      push_word(rand_word(OP_SPARE));

      set_config(FMT_BMP, MODE_GRAY, 0);
      send_pixel(7, 8'hA5, 8'd0, 8'd0);
      set_config(FMT_PNG, MODE_SPARE, 0);
      send_pixel(7, 8'd255, 8'd0, 8'd0);

      // hold the receiver off while the sender keeps offering words
      set_config(FMT_PNG, MODE_RGB, 0);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (30) send_pixel(0, rand_comp(), rand_comp(), rand_comp());
      settle();

      while (words_sent < ITEM_TARGET) begin
         run_phase(phase_no);
         phase_no++;
      end

      settle();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
